[hdl/sorted_priority_queue_defines.svh]
// Assertion macros for the sorted priority queue.
// SPQ_ASSERT_NOW:  antecedent and consequent in the same cycle.
// SPQ_ASSERT_NEXT: consequent in the cycle after the antecedent.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sorted_priority_queue: check failed");
`define SPQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sorted_priority_queue: check failed");
`else
`define SPQ_ASSERT_NOW(label, clk, rstn, ante, cons)
`define SPQ_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

[hdl/spq_pkg.sv]
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int COUNT_OUT_W   = 5;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } spq_status_t;

    // Broadcast to every cell: what happens this cycle
    typedef struct packed {
        logic              enq;
        logic              deq;
        logic [DATA_W-1:0] ent_val;
        logic [DATA_W-1:0] ent_pri;
    } spq_op_t;

    // What a cell shows its neighbors
    typedef struct packed {
        logic              le;
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] pri;
    } spq_link_t;

endpackage

[hdl/spq_cell.sv]
module spq_cell (
    input  logic              aclk,
    input  spq_pkg::spq_op_t  op,
    input  logic              valid,
    input  spq_pkg::spq_link_t prev,
    input  spq_pkg::spq_link_t next,
    output spq_pkg::spq_link_t link
);

    logic [spq_pkg::DATA_W-1:0] val_reg, val_next;
    logic [spq_pkg::DATA_W-1:0] pri_reg, pri_next;
    logic                       le;

    // Entry stays put when it sorts at or before the new one (keeps arrival order)
    assign le = valid && ($signed(pri_reg) <= $signed(op.ent_pri));

    always_comb begin
        val_next = val_reg;
        pri_next = pri_reg;
        if (op.enq && !le) begin
            if (prev.le) begin
                val_next = op.ent_val;
                pri_next = op.ent_pri;
            end else begin
                val_next = prev.val;
                pri_next = prev.pri;
            end
        end else if (op.deq) begin
            val_next = next.val;
            pri_next = next.pri;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
        pri_reg <= pri_next;
    end

    assign link.le  = le;
    assign link.val = val_reg;
    assign link.pri = pri_reg;

endmodule

[hdl/sorted_priority_queue.sv]
// Channel   Dir  Payload                                      Handshake
// s_axis    in   tuser: cmd; tdata: entry_value, entry_priority  tvalid/tready
// m_axis    out  tdata: status, head/tail value, count, empty    tvalid/tready
//
// One transaction per cycle while s_axis_tready is high: every cell compares
// its priority with the new entry and shifts or holds in the same cycle, so the
// insert or remove takes effect at acceptance; the result appears on m_axis the cycle after acceptance.
// Reset (aresetn low, synchronous) clears the fill count and the result valid;
// slot contents are not cleared and are not read until written.
// s_axis_tready is low only while a result is held and m_axis_tready is low.
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [31:0] entry_value, [63:32] entry_priority
    input  logic [0:0]  s_axis_tuser,  // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata  // [1:0] status, [33:2] head_value,
                                      // [65:34] tail_value, [70:66] entry_count,
                                      // [71] is_empty
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DW    = spq_pkg::DATA_W;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DW-1:0]     tail_reg, tail_next;
    logic              m_valid_reg;
    spq_pkg::spq_status_t res_status_reg, status_next;
    logic [DW-1:0]     res_head_reg, res_tail_reg, head_next;
    logic [CNT_W-1:0]  res_count_reg;
    logic              res_empty_reg;

    logic              s_acc;
    logic              full, empty;
    logic              is_enq;
    spq_pkg::spq_op_t  op;
    spq_pkg::spq_link_t link [DEPTH];
    spq_pkg::spq_link_t tie_first, tie_last;
    logic [DEPTH-1:0]  valid_vec, le_vec;
    logic              ins_at_end;
    logic [DW-1:0]     second_val;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign full          = (count_reg == CNT_W'(DEPTH));
    assign empty         = (count_reg == '0);
    assign is_enq        = (s_axis_tuser[0] == spq_pkg::CMD_ENQ);

    assign op.enq     = s_acc && is_enq && !full;
    assign op.deq     = s_acc && !is_enq && !empty;
    assign op.ent_val = s_axis_tdata[31:0];
    assign op.ent_pri = s_axis_tdata[63:32];

    assign tie_first = '{le: 1'b1, val: '0, pri: '0};
    assign tie_last  = '{le: 1'b0, val: '0, pri: '0};

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            spq_pkg::spq_link_t prev_l, next_l;
            assign valid_vec[gi] = (CNT_W'(gi) < count_reg);
            assign le_vec[gi]    = link[gi].le;
            if (gi == 0) begin : g_first
                assign prev_l = tie_first;
            end else begin : g_mid_p
                assign prev_l = link[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign next_l = tie_last;
            end else begin : g_mid_n
                assign next_l = link[gi+1];
            end
            spq_cell u_cell (
                .aclk  (aclk),
                .op    (op),
                .valid (valid_vec[gi]),
                .prev  (prev_l),
                .next  (next_l),
                .link  (link[gi])
            );
        end
        if (DEPTH > 1) begin : g_second
            assign second_val = link[1].val;
        end else begin : g_no_second
            assign second_val = '0;
        end
    endgenerate

    // New entry lands at the tail when every held entry sorts at or before it
    assign ins_at_end = ~|(valid_vec & ~le_vec);

    always_comb begin
        count_next  = count_reg;
        tail_next   = tail_reg;
        head_next   = link[0].val;
        status_next = spq_pkg::STAT_DONE;
        priority if (op.enq) begin
            count_next = count_reg + CNT_W'(1);
            if (ins_at_end) begin
                tail_next = op.ent_val;
            end
            if (!link[0].le) begin
                head_next = op.ent_val;
            end
        end else if (op.deq) begin
            count_next = count_reg - CNT_W'(1);
            head_next  = second_val;
        end else if (is_enq) begin
            status_next = spq_pkg::STAT_FULL;
        end else begin
            status_next = spq_pkg::STAT_EMPTY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            tail_reg       <= tail_next;
            res_status_reg <= status_next;
            res_count_reg  <= count_next;
            res_empty_reg  <= (count_next == '0);
            res_head_reg   <= (count_next == '0) ? '0 : head_next;
            res_tail_reg   <= (count_next == '0) ? '0 : tail_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {res_empty_reg,
                            spq_pkg::COUNT_OUT_W'(res_count_reg),
                            res_tail_reg,
                            res_head_reg,
                            res_status_reg};

    `SPQ_ASSERT_NOW(a_count_range, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `SPQ_ASSERT_NEXT(a_enq_grows, aclk, aresetn, op.enq, count_reg == $past(count_reg) + CNT_W'(1))
    `SPQ_ASSERT_NEXT(a_deq_shrinks, aclk, aresetn, op.deq, count_reg == $past(count_reg) - CNT_W'(1))
    `SPQ_ASSERT_NOW(a_empty_flag, aclk, aresetn, m_valid_reg, res_empty_reg == (res_count_reg == '0))
    `SPQ_ASSERT_NOW(a_empty_zero, aclk, aresetn, m_valid_reg && res_empty_reg, res_head_reg == '0 && res_tail_reg == '0)

endmodule

[test/sorted_priority_queue_tb.sv]
module sorted_priority_queue_tb;

    localparam int DEPTH        = spq_pkg::DEPTH_DEFAULT;
    localparam int RAND_ITEMS   = 1826;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;
    localparam int SQUEEZE_AT   = 400;
    localparam int SQUEEZE_LEN  = 300;

    typedef struct {
        logic                       cmd;
        logic [spq_pkg::DATA_W-1:0] val;
        logic [spq_pkg::DATA_W-1:0] pri;
    } spq_item_t;

    typedef struct {
        spq_pkg::spq_status_t            status;
        logic [spq_pkg::DATA_W-1:0]      head;
        logic [spq_pkg::DATA_W-1:0]      tail;
        logic [spq_pkg::COUNT_OUT_W-1:0] count;
        logic                            empty;
    } spq_report_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;  // [31:0] entry_value, [63:32] entry_priority
    logic [0:0]  s_axis_tuser  = '0;  // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // [1:0] status, [33:2] head_value,
                                      // [65:34] tail_value, [70:66] entry_count,
                                      // [71] is_empty

    sorted_priority_queue #(.DEPTH(DEPTH)) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    spq_item_t   pending_items[$];
    spq_report_t predicted_reports[$];

    // shadow copy of the sorted list
    logic [spq_pkg::DATA_W-1:0] shadow_val[DEPTH];
    logic [spq_pkg::DATA_W-1:0] shadow_pri[DEPTH];
    int                         shadow_fill = 0;

    int items_sent    = 0;
    int items_taken   = 0;
    int results_seen  = 0;
    int error_count   = 0;
    int tx_gap        = 0;
    int rx_hold       = 0;
    bit squeeze_done  = 1'b0;
    bit calm          = 1'b0;
    int calm_ticks    = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 results_seen, what, got, want);
        error_count++;
    endtask

    // insert after all entries of lower or equal priority; remove from head
    task automatic model_queue_op(input spq_item_t op, output spq_report_t rep);
        int pos;
        rep.status = spq_pkg::STAT_DONE;
        if (op.cmd == spq_pkg::CMD_ENQ) begin
            if (shadow_fill >= DEPTH) begin
                rep.status = spq_pkg::STAT_FULL;
            end else begin
                pos = shadow_fill;
                while (pos > 0 && $signed(shadow_pri[pos-1]) > $signed(op.pri)) begin
                    shadow_val[pos] = shadow_val[pos-1];
                    shadow_pri[pos] = shadow_pri[pos-1];
                    pos--;
                end
                shadow_val[pos] = op.val;
                shadow_pri[pos] = op.pri;
                shadow_fill++;
            end
        end else begin
            if (shadow_fill == 0) begin
                rep.status = spq_pkg::STAT_EMPTY;
            end else begin
                for (pos = 1; pos < shadow_fill; pos++) begin
                    shadow_val[pos-1] = shadow_val[pos];
                    shadow_pri[pos-1] = shadow_pri[pos];
                end
                shadow_fill--;
            end
        end
        rep.head  = (shadow_fill == 0) ? '0 : shadow_val[0];
        rep.tail  = (shadow_fill == 0) ? '0 : shadow_val[shadow_fill-1];
        rep.count = shadow_fill[spq_pkg::COUNT_OUT_W-1:0];
        rep.empty = (shadow_fill == 0);
    endtask

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_item(input logic cmd, input logic [31:0] val,
                             input logic [31:0] pri);
        spq_item_t it;
        it.cmd = cmd;
        it.val = val;
        it.pri = pri;
        pending_items.push_back(it);
    endtask

    // pri_mode: 0 full range, 1 narrow range for ties, 2 extremes
    function automatic logic [31:0] pick_priority(input int pri_mode);
        case (pri_mode)
            1:       return $urandom_range(0, 7) - 4;
            2: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // switch between idle-free stretches and normal traffic
    always @(posedge aclk) begin
        calm_ticks++;
        if (calm_ticks % 400 == 0)
            calm = ($urandom_range(0, 3) == 0);
    end

    // driver
    always @(negedge aclk) begin
        spq_item_t nxt;
        bit        slot_free;
        slot_free = !s_axis_tvalid || (items_taken == items_sent);
        if (aresetn && slot_free) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                nxt = pending_items.pop_front();
                s_axis_tdata  <= {nxt.pri, nxt.val};
                s_axis_tuser  <= nxt.cmd;
                s_axis_tvalid <= 1'b1;
                items_sent++;
                tx_gap = pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off to back up the input side
    always @(negedge aclk) begin
        int gap;
        if (aresetn) begin
            if (!squeeze_done && results_seen >= SQUEEZE_AT) begin
                squeeze_done = 1'b1;
                rx_hold = SQUEEZE_LEN;
                m_axis_tready <= 1'b0;
            end else if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    rx_hold = gap - 1;
                end
            end
        end
    end

    // monitor: results first, then the transaction accepted at this edge
    always @(posedge aclk) begin
        spq_report_t want;
        spq_report_t got;
        spq_item_t   taken;
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                got.status = spq_pkg::spq_status_t'(m_axis_tdata[1:0]);
                got.head   = m_axis_tdata[33:2];
                got.tail   = m_axis_tdata[65:34];
                got.count  = m_axis_tdata[70:66];
                got.empty  = m_axis_tdata[71];
                if (predicted_reports.size() == 0) begin
                    flag_mismatch("unexpected result, status", got.status, '0);
                end else begin
                    want = predicted_reports.pop_front();
                    if (got.status !== want.status)
                        flag_mismatch("status", got.status, want.status);
                    if (got.head !== want.head)
                        flag_mismatch("head_value", got.head, want.head);
                    if (got.tail !== want.tail)
                        flag_mismatch("tail_value", got.tail, want.tail);
                    if (got.count !== want.count)
                        flag_mismatch("entry_count", got.count, want.count);
                    if (got.empty !== want.empty)
                        flag_mismatch("is_empty", got.empty, want.empty);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                taken.cmd = s_axis_tuser[0];
                taken.val = s_axis_tdata[31:0];
                taken.pri = s_axis_tdata[63:32];
                model_queue_op(taken, want);
                predicted_reports.push_back(want);
                items_taken++;
            end
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial begin
        int n;
        int k;
        int seg_len;
        int enq_pct;
        int pri_mode;

        // directed: empty dequeue, extremes, ties, full, partial drain
        push_item(spq_pkg::CMD_DEQ, 32'h1234_5678, 32'h8765_4321);
        push_item(spq_pkg::CMD_ENQ, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push_item(spq_pkg::CMD_ENQ, 32'h8000_0000, 32'h8000_0000);
        push_item(spq_pkg::CMD_ENQ, 32'h0000_0001, 32'h0000_0000);
        push_item(spq_pkg::CMD_ENQ, 32'h0000_0002, 32'h0000_0000);
        push_item(spq_pkg::CMD_ENQ, 32'h0000_0003, 32'hFFFF_FFFF);
        push_item(spq_pkg::CMD_ENQ, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        for (k = 0; k < DEPTH - 6; k++)
            push_item(spq_pkg::CMD_ENQ, 32'h100 + k, 32'h0000_0005);
        push_item(spq_pkg::CMD_ENQ, 32'hDEAD_BEEF, 32'h8000_0000);
        for (k = 0; k < 6; k++)
            push_item(spq_pkg::CMD_DEQ, $urandom, $urandom);

        n = 0;
        while (n < RAND_ITEMS) begin
            seg_len  = $urandom_range(20, 80);
            pri_mode = $urandom_range(0, 2);
            case ($urandom_range(0, 2))
                0:       enq_pct = 90;
                1:       enq_pct = 50;
                default: enq_pct = 15;
            endcase
            for (k = 0; k < seg_len && n < RAND_ITEMS; k++) begin
                if ($urandom_range(0, 99) < enq_pct)
                    push_item(spq_pkg::CMD_ENQ, $urandom, pick_priority(pri_mode));
                else
                    push_item(spq_pkg::CMD_DEQ, $urandom, $urandom);
                n++;
            end
        end

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() > 0 || s_axis_tvalid || predicted_reports.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (predicted_reports.size() != 0)
            flag_mismatch("results never seen, count", predicted_reports.size(), 0);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
test/sorted_priority_queue_tb.sv
